// ===== rtl/mt_pkg.sv =====
// ============================================================================
// mt_pkg
// Shared types and constants of the MT19937 generator.
// ============================================================================
package mt_pkg;

    localparam int STATE_WORDS = 624;
    localparam int IDX_W       = 10;
    localparam int MT_SHIFT    = 397;

    localparam logic [31:0] MT_MATRIX    = 32'h9908_B0DF;
    localparam logic [31:0] MT_TEMPER_B  = 32'h9D2C_5680;
    localparam logic [31:0] MT_TEMPER_C  = 32'hEFC6_0000;
    localparam logic [31:0] MT_INIT_MULT = 32'd1812433253;
    localparam logic [31:0] SEED_RESET   = 32'd5489;

    localparam logic [1:0] FUNC_WORD  = 2'd0;
    localparam logic [1:0] FUNC_PAIR  = 2'd1;
    localparam logic [1:0] FUNC_RANGE = 2'd2;
    localparam logic [1:0] FUNC_NONE  = 2'd3;

    typedef struct packed {
        logic [1:0]         func;
        logic signed [31:0] range_min;
        logic signed [31:0] range_max;
    } mt_in_t;

    typedef struct packed {
        logic [63:0] rand_value;
        logic        bad_range;
    } mt_out_t;

    // controller to datapath
    typedef struct packed {
        logic       seed_start;  // load seed, word 0
        logic       seed_step;   // write next seeded word
        logic       tw_rd;       // issue twist reads for addr
        logic       tw_wr;       // write twisted word
        logic       draw_rd;     // read word at word index
        logic       take_hi;     // tempered word to upper half
        logic       take_lo;     // tempered word to lower half
        logic       mod_start;
        logic       mod_step;
        logic       finish;      // build result register
        logic       clr_index;
        logic [IDX_W-1:0] addr;  // word address for seed/twist
    } mt_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic             need_twist;
        logic             mod_done;
    } mt_sts_t;

    function automatic logic [31:0] temper(input logic [31:0] x);
        logic [31:0] y;
        y = x ^ (x >> 11);
        y = y ^ ((y << 7) & MT_TEMPER_B);
        y = y ^ ((y << 15) & MT_TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

// ===== rtl/mt_datapath.sv =====
// ============================================================================
// mt_datapath
// State memory, twist and seed arithmetic, tempering and restoring modulo.
// ============================================================================
module mt_datapath
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic [31:0]     seed_value,
    input  mt_pkg::mt_in_t  req,
    input  mt_pkg::mt_cmd_t cmd,
    output mt_pkg::mt_sts_t sts,
    output mt_pkg::mt_out_t result
);
    import mt_pkg::*;

    // memory copies: three read ports, every copy gets each write
    logic [31:0] mem_a [STATE_WORDS];
    logic [31:0] mem_b [STATE_WORDS];
    logic [31:0] mem_c [STATE_WORDS];
    logic [31:0] rd_a_reg, rd_b_reg, rd_c_reg;

    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [31:0]      wr_data;
    logic [IDX_W-1:0] ra, rb, rc;

    logic [IDX_W-1:0] index_reg, index_next;
    logic [IDX_W-1:0] wr_pend_reg;
    logic [31:0]      seed_mul_reg;       // registered product stage
    logic [63:0]      value_reg;
    logic [31:0]      word_reg;
    logic [32:0]      rem_reg, div_reg;
    logic [31:0]      quo_src_reg;
    logic [5:0]       bit_reg;
    logic             mod_done_reg;
    mt_out_t          result_reg;

    logic signed [32:0] span_s;
    logic [32:0]        span;
    logic               bad;
    logic [32:0]        trial;
    logic [31:0]        y;
    logic [IDX_W-1:0]   addr_p1, addr_pm;

    always_comb
    begin
        addr_p1 = (cmd.addr == IDX_W'(STATE_WORDS - 1)) ? '0 : cmd.addr + 1'b1;
        addr_pm = (cmd.addr >= IDX_W'(STATE_WORDS - MT_SHIFT))
                ? cmd.addr - IDX_W'(STATE_WORDS - MT_SHIFT)
                : cmd.addr + IDX_W'(MT_SHIFT);
        ra = cmd.draw_rd ? index_reg : cmd.addr;
        rb = addr_p1;
        rc = addr_pm;
    end

    always_comb
    begin
        y = {rd_a_reg[31], rd_b_reg[30:0]};
        wr_en   = 1'b0;
        wr_addr = wr_pend_reg;
        wr_data = '0;
        if (cmd.seed_start) begin
            wr_en = 1'b1; wr_addr = '0; wr_data = seed_value;
        end else if (cmd.seed_step) begin
            wr_en = 1'b1; wr_addr = cmd.addr;
            wr_data = seed_mul_reg + 32'(cmd.addr);
        end else if (cmd.tw_wr) begin
            wr_en = 1'b1;
            wr_data = rd_c_reg ^ (y >> 1) ^ (y[0] ? MT_MATRIX : '0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            mem_a[wr_addr] <= wr_data;
            mem_b[wr_addr] <= wr_data;
            mem_c[wr_addr] <= wr_data;
        end
        rd_a_reg <= mem_a[ra];
        rd_b_reg <= mem_b[rb];
        rd_c_reg <= mem_c[rc];
    end

    always_comb
    begin
        span_s = 33'(req.range_max) - 33'(req.range_min);
        bad    = span_s[32];
        span   = 33'(span_s) + 33'd1;
        trial  = {rem_reg[31:0], quo_src_reg[31]} - div_reg;
    end

    always_comb
    begin
        index_next = index_reg;
        if (cmd.clr_index) index_next = '0;
        else if (cmd.draw_rd) index_next = index_reg + 1'b1;
        if (cmd.seed_start) index_next = IDX_W'(STATE_WORDS);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            index_reg    <= IDX_W'(STATE_WORDS);
            mod_done_reg <= 1'b0;
        end else begin
            index_reg    <= index_next;
            if (cmd.mod_start) mod_done_reg <= 1'b0;
            else if (cmd.mod_step && bit_reg == 6'd0) mod_done_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        wr_pend_reg <= cmd.addr;
        // product for the word after the one written this cycle
        seed_mul_reg <= MT_INIT_MULT * (wr_data ^ (wr_data >> 30));
        if (cmd.take_hi) value_reg[63:32] <= temper(rd_a_reg);
        if (cmd.take_lo) value_reg[31:0]  <= temper(rd_a_reg);
        if (cmd.take_lo) word_reg         <= temper(rd_a_reg) >> 1;
        if (cmd.mod_start) begin
            rem_reg     <= '0;
            div_reg     <= span;
            quo_src_reg <= word_reg;
            bit_reg     <= 6'd31;
        end else if (cmd.mod_step && !mod_done_reg) begin
            rem_reg     <= trial[32] ? {rem_reg[31:0], quo_src_reg[31]} : trial;
            quo_src_reg <= quo_src_reg << 1;
            bit_reg     <= bit_reg - 1'b1;
        end
        if (cmd.finish) begin
            result_reg.bad_range <= 1'b0;
            unique case (req.func)
                FUNC_WORD:  result_reg.rand_value <= {32'd0, value_reg[31:0]};
                FUNC_PAIR:  result_reg.rand_value <= value_reg;
                FUNC_RANGE:
                begin
                    result_reg.bad_range  <= bad;
                    result_reg.rand_value <= bad ? '0
                        : {32'd0, req.range_min + rem_reg[31:0]};
                end
                default:    result_reg.rand_value <= '0;
            endcase
        end
    end

    assign sts.need_twist = (index_reg >= IDX_W'(STATE_WORDS));
    assign sts.mod_done   = mod_done_reg;
    assign result         = result_reg;

endmodule

// ===== rtl/mt_ctrl.sv =====
// ============================================================================
// mt_ctrl
// Sequencer for seeding, twisting, drawing words and the modulo.
// ============================================================================
module mt_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            seed_wr,
    input  logic            in_fire,
    input  logic [1:0]      func,
    input  mt_pkg::mt_sts_t sts,
    output mt_pkg::mt_cmd_t cmd,
    output logic            in_ready,
    output logic            out_load
);
    import mt_pkg::*;

    typedef enum logic [8:0] {
        S_SEED   = 9'b000000001,
        S_IDLE   = 9'b000000010,
        S_TWRD   = 9'b000000100,
        S_TWWR   = 9'b000001000,
        S_DRAW   = 9'b000010000,
        S_TAKE   = 9'b000100000,
        S_MODST  = 9'b001000000,
        S_MOD    = 9'b010000000,
        S_DONE   = 9'b100000000
    } st_t;

    st_t              st_reg, st_next;
    logic [IDX_W-1:0] addr_reg, addr_next;
    logic             first_reg, first_next;  // pair: upper half pending
    logic             start_reg;               // seed word 0 pending

    always_comb
    begin
        st_next    = st_reg;
        addr_next  = addr_reg;
        first_next = first_reg;
        cmd        = '0;
        cmd.addr   = addr_reg;
        in_ready   = 1'b0;
        out_load   = 1'b0;
        unique case (st_reg)
            S_SEED:
            begin
                if (start_reg) begin
                    cmd.seed_start = 1'b1;
                    addr_next = IDX_W'(1);
                end else begin
                    cmd.seed_step = 1'b1;
                    if (addr_reg == IDX_W'(STATE_WORDS - 1)) st_next = S_IDLE;
                    else addr_next = addr_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_fire) begin
                    first_next = (func == FUNC_PAIR);
                    st_next = (func == FUNC_NONE) ? S_DONE : S_DRAW;
                end
            end
            S_DRAW:
            begin
                if (sts.need_twist) begin
                    addr_next = '0;
                    st_next = S_TWRD;
                end else begin
                    cmd.draw_rd = 1'b1;
                    st_next = S_TAKE;
                end
            end
            S_TWRD:
            begin
                cmd.tw_rd = 1'b1;
                st_next = S_TWWR;
            end
            S_TWWR:
            begin
                cmd.tw_wr = 1'b1;
                if (addr_reg == IDX_W'(STATE_WORDS - 1)) begin
                    cmd.clr_index = 1'b1;
                    st_next = S_DRAW;
                end else begin
                    addr_next = addr_reg + 1'b1;
                    st_next = S_TWRD;
                end
            end
            S_TAKE:
            begin
                if (first_reg) begin
                    cmd.take_hi = 1'b1;
                    first_next = 1'b0;
                    st_next = S_DRAW;
                end else begin
                    cmd.take_lo = 1'b1;
                    st_next = (func == FUNC_RANGE) ? S_MODST : S_DONE;
                end
            end
            S_MODST:
            begin
                cmd.mod_start = 1'b1;
                st_next = S_MOD;
            end
            S_MOD:
            begin
                cmd.mod_step = 1'b1;
                if (sts.mod_done) st_next = S_DONE;
            end
            S_DONE:
            begin
                cmd.finish = 1'b1;
                out_load = 1'b1;
                st_next = S_IDLE;
            end
            default: st_next = S_IDLE;
        endcase
        if (seed_wr) begin
            st_next   = S_SEED;
            addr_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            st_reg    <= S_SEED;
            addr_reg  <= '0;
            first_reg <= 1'b0;
            start_reg <= 1'b1;
        end else begin
            st_reg    <= st_next;
            addr_reg  <= addr_next;
            first_reg <= first_next;
            start_reg <= seed_wr;
        end
    end

endmodule

// ===== rtl/mersenne_twister_prng.sv =====
// ============================================================================
// mersenne_twister_prng
// MT19937 generator with word, pair and ranged-integer requests.
// ============================================================================
// After reset or a seed write the block seeds its 624-word state, one word
// per cycle, before it takes a request. A pair request draws two words, and
// a ranged request then runs the one-bit-per-cycle modulo. Every 624th word
// first runs the twist, which reads and then writes each state word in turn
// through the three-port state memory. The result waits in an output
// register; the next request is taken once the previous result has left it.
module mersenne_twister_prng
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_we,
    input  logic [31:0]    cfg_wdata,
    input  logic           in_valid,
    output logic           in_ready,
    input  mt_pkg::mt_in_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output mt_pkg::mt_out_t out_data
);
    import mt_pkg::*;

    mt_cmd_t     cmd;
    mt_sts_t     sts;
    mt_out_t     res;
    mt_in_t      req_reg;
    logic [31:0] seed_reg;
    logic        ctrl_ready, out_load, in_fire, out_valid_reg;

    assign in_ready = ctrl_ready && !out_valid_reg;
    assign in_fire  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            seed_reg      <= SEED_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) seed_reg <= cfg_wdata;
            if (out_valid_reg && out_ready) out_valid_reg <= 1'b0;
            if (out_load) out_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire) req_reg <= in_data;
    end

    // result register of datapath feeds out_data directly
    assign out_valid = out_valid_reg;
    assign out_data  = res;

    mt_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .seed_wr  (cfg_we),
        .in_fire  (in_fire),
        .func     (in_fire ? in_data.func : req_reg.func),
        .sts      (sts),
        .cmd      (cmd),
        .in_ready (ctrl_ready),
        .out_load (out_load)
    );

    mt_datapath u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .seed_value (cfg_we ? cfg_wdata : seed_reg),
        .req        (req_reg),
        .cmd        (cmd),
        .sts        (sts),
        .result     (res)
    );

endmodule

// ===== rtl/mt_checker.sv =====
// ============================================================================
// mt_checker
// Port-level checks of the generator, bound to the top level.
// ============================================================================
module mt_checker
(
    input logic            clk,
    input logic            rst_n,
    input logic            in_valid,
    input logic            in_ready,
    input logic            out_valid,
    input logic            out_ready,
    input mt_pkg::mt_out_t out_data
);
    import mt_pkg::*;

    // one item in flight: no new item while a result waits
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("input taken while result pending");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // bad range only flags with a zero value
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.bad_range |-> out_data.rand_value == 64'd0)
        else $error("bad range with nonzero value");

    // a result must not be valid straight after an item is taken
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !out_valid) else $error("result too early");

endmodule

bind mersenne_twister_prng mt_checker u_mt_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

// ===== bench/mersenne_twister_prng_tb.sv =====
// ============================================================================
// mersenne_twister_prng_tb
// Self-checking bench for the MT19937 generator: directed and random word,
// pair and ranged requests under several seeds, checked against a local
// generator model with randomized sender gaps and receiver stalls.
// ============================================================================
module mersenne_twister_prng_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import mt_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 60;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    cfg_we = 1'b0;
    logic [31:0] cfg_wdata = '0;
    logic    in_valid = 1'b0;
    logic    in_ready;
    mt_in_t  in_data = '0;
    logic    out_valid;
    logic    out_ready = 1'b0;
    mt_out_t out_data;

    int      errors = 0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;
    int      stuck_cycles = 0;
    mt_out_t expected_q[$];

    // local copy of the generator state
    logic [31:0] mt_words[STATE_WORDS];
    int          mt_pos;

    always #2 clk = ~clk;

    mersenne_twister_prng u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    function automatic void reseed_model(input logic [31:0] s);
        logic [31:0] p;
        mt_words[0] = s;
        for (int i = 1; i < STATE_WORDS; i++)
        begin
            p = mt_words[i-1];
            mt_words[i] = MT_INIT_MULT * (p ^ (p >> 30)) + 32'(i);
        end
        mt_pos = STATE_WORDS;
    endfunction

    function automatic logic [31:0] draw_word();
        logic [31:0] y;
        logic [31:0] nxt;
        if (mt_pos >= STATE_WORDS)
        begin
            for (int i = 0; i < STATE_WORDS; i++)
            begin
                nxt = mt_words[(i + 1) % STATE_WORDS];
                y = (mt_words[i] & 32'h8000_0000) | (nxt & 32'h7FFF_FFFF);
                mt_words[i] = mt_words[(i + MT_SHIFT) % STATE_WORDS] ^ (y >> 1)
                              ^ (y[0] ? MT_MATRIX : 32'h0);
            end
            mt_pos = 0;
        end
        y = mt_words[mt_pos];
        mt_pos++;
        y ^= y >> 11;
        y ^= (y << 7) & MT_TEMPER_B;
        y ^= (y << 15) & MT_TEMPER_C;
        y ^= y >> 18;
        return y;
    endfunction

    function automatic mt_out_t predict_result(input mt_in_t req);
        mt_out_t r;
        longint  lo;
        longint  hi;
        longint  sum;
        logic [31:0] w;
        r = '0;
        case (req.func)
            FUNC_WORD: r.rand_value = {32'h0, draw_word()};
            FUNC_PAIR:
            begin
                r.rand_value[63:32] = draw_word();
                r.rand_value[31:0]  = draw_word();
            end
            FUNC_RANGE:
            begin
                lo = longint'(req.range_min);
                hi = longint'(req.range_max);
                w  = draw_word() >> 1;
                if (hi < lo)
                    r.bad_range = 1'b1;
                else
                begin
                    sum = lo + (longint'(w) % (hi - lo + 1));
                    r.rand_value = {32'h0, sum[31:0]};
                end
            end
            default: r = '0;
        endcase
        return r;
    endfunction

    // receiver stalls
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    // result checker and watchdog
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected item, actual %h/%b", $time,
                         out_data.rand_value, out_data.bad_range);
                errors++;
            end
            else
            begin
                if (out_data.rand_value !== expected_q[0].rand_value)
                begin
                    $display("%0t: rand_value expected %h actual %h", $time,
                             expected_q[0].rand_value, out_data.rand_value);
                    errors++;
                end
                if (out_data.bad_range !== expected_q[0].bad_range)
                begin
                    $display("%0t: bad_range expected %b actual %b", $time,
                             expected_q[0].bad_range, out_data.bad_range);
                    errors++;
                end
                void'(expected_q.pop_front());
            end
        end
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // entered and left at a rising edge; valid stays up across back-to-back items
    task automatic send_request(input mt_in_t req);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do @(posedge clk); while (!in_ready);
        expected_q.push_back(predict_result(req));
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_seed(input logic [31:0] s);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= s;
        @(posedge clk);
        cfg_we <= 1'b0;
        reseed_model(s);
    endtask

    function automatic mt_in_t make_range(input logic [31:0] lo, input logic [31:0] hi);
        mt_in_t r;
        r.func = FUNC_RANGE;
        r.range_min = lo;
        r.range_max = hi;
        return r;
    endfunction

    function automatic mt_in_t random_request();
        mt_in_t r;
        int     pick;
        logic [31:0] base;
        pick = $urandom_range(99);
        r.range_min = $urandom;
        r.range_max = $urandom;
        if (pick < 30)
            r.func = FUNC_WORD;
        else if (pick < 55)
            r.func = FUNC_PAIR;
        else if (pick < 95)
        begin
            r.func = FUNC_RANGE;
            // mostly well-formed ranges, some narrow, the rest fully random
            if ($urandom_range(3) != 0)
            begin
                base = $urandom;
                r.range_min = base;
                r.range_max = base + ($urandom_range(1) ? $urandom_range(1000)
                                                        : ($urandom >> 1));
                if ($signed(r.range_max) < $signed(r.range_min))
                    r.range_max = 32'h7FFF_FFFF;
            end
        end
        else
            r.func = FUNC_NONE;
        return r;
    endfunction

    task automatic test_directed();
        mt_in_t r;
        r = '0;
        r.func = FUNC_WORD;
        send_request(r);
        send_request(r);
        r.func = FUNC_PAIR;
        send_request(r);
        r.func = FUNC_NONE;
        r.range_min = 32'hFFFF_FFFF;
        r.range_max = 32'hFFFF_FFFF;
        send_request(r);
        send_request(make_range(32'd0, 32'd9));
        send_request(make_range(32'd5, 32'd5));
        send_request(make_range(32'hFFFF_FFF6, 32'd10));
        // full span, single-value and half-span ranges
        send_request(make_range(32'h8000_0000, 32'h7FFF_FFFF));
        send_request(make_range(32'h8000_0000, 32'h8000_0000));
        send_request(make_range(32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_request(make_range(32'h0, 32'h7FFF_FFFF));
        send_request(make_range(32'h8000_0000, 32'hFFFF_FFFF));
        // bad ranges, then one wide range across zero
        send_request(make_range(32'd1, 32'd0));
        send_request(make_range(32'h7FFF_FFFF, 32'h8000_0000));
        send_request(make_range(32'h5555_5555, 32'hAAAA_AAAA));
        send_request(make_range(32'hAAAA_AAAA, 32'h5555_5555));
        r.func = FUNC_WORD;
        send_request(r);
    endtask

    task automatic test_random(input int count, input int idle_pct, input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < count; i++)
        begin
            if (i == count / 2)
                wait_drained();
            send_request(random_request());
        end
    endtask

    task automatic test_seeds();
        write_seed(32'h0);
        test_random(100, 10, 10);
        write_seed(32'hFFFF_FFFF);
        test_random(100, 10, 10);
        write_seed($urandom);
        test_random(100, 0, 0);
        write_seed(SEED_RESET);
        test_random(50, 0, 0);
    endtask

    initial
    begin
        reseed_model(SEED_RESET);
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(350, 22, 69);
        test_random(350, 69, 22);
        test_random(350, 0, 0);
        test_seeds();
        wait_drained();
        if (errors == 0 && expected_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== mersenne_twister_prng.f =====
rtl/mt_pkg.sv
rtl/mt_datapath.sv
rtl/mt_ctrl.sv
rtl/mersenne_twister_prng.sv
rtl/mt_checker.sv
bench/mersenne_twister_prng_tb.sv
